/* hw/rtl/cfo_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package cfo_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_W         = 31;
  localparam int CFG_IDX_W     = 2;

  localparam logic [CFG_W-1:0] CFG_RESET    = 31'd65536;
  // weight below 0.0001 means weight * 10000 below one
  localparam logic [13:0]      WEIGHT_SCALE = 14'd10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WEIGHT    = 2'd0,
    CFG_INFLUENCE = 2'd1,
    CFG_GAIN      = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic kill;
    logic c2_zero;
    logic neg_x;
    logic neg_y;
  } side_t;

  typedef struct packed {
    logic        neg;
    logic [63:0] m;
  } dot_t;

  function automatic logic [31:0] mag32(input logic [31:0] a);
    return a[31] ? (~a + 32'd1) : a;
  endfunction

  // combine two signed products given as sign and magnitude
  function automatic dot_t dot_comb(input logic [63:0] m1, input logic [63:0] m2,
                                    input logic n1, input logic n2);
    dot_t        d;
    logic [64:0] diff;
    diff = {1'b0, m1} - {1'b0, m2};
    if (n1 == n2) begin
      d.neg = n1;
      d.m   = m1 + m2;
    end else if (!diff[64]) begin
      d.neg = n1;
      d.m   = diff[63:0];
    end else begin
      d.neg = n2;
      d.m   = m2 - m1;
    end
    if (d.m == 64'd0) d.neg = 1'b0;
    return d;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/cfo_delay.sv */
`timescale 1ns / 1ps
`default_nettype none
module cfo_delay
  import cfo_pkg::*;
#(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  if (N == 0) begin : g_none
    assign dout = din;
  end else begin : g_line
    logic [W-1:0] sr [N];
    // advance the line on enable
    always_ff @(posedge clk) begin
      if (en) begin
        sr[0] <= din;
        for (int i = 1; i < N; i++) sr[i] <= sr[i-1];
      end
    end
    assign dout = sr[N-1];
  end

endmodule
`default_nettype wire

/* hw/rtl/cfo_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module cfo_div
  import cfo_pkg::*;
#(
  parameter int NW = 80,
  parameter int DW = 64,
  parameter int QW = 48
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  // one quotient bit per stage; upper numerator bits seed the remainder
  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] acc_q [QW];
  logic [DW-1:0] den_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DW-1:0] r_p;
    logic [QW-1:0] a_p;
    logic [DW-1:0] d_p;
    logic [DW:0]   t;
    logic [DW:0]   diff;
    if (i == 0) begin : g_first
      assign r_p = DW'(num[NW-1:QW]);
      assign a_p = num[QW-1:0];
      assign d_p = den;
    end else begin : g_next
      assign r_p = rem_q[i-1];
      assign a_p = acc_q[i-1];
      assign d_p = den_q[i-1];
    end
    assign t    = {r_p, a_p[QW-1]};
    assign diff = t - {1'b0, d_p};
    always_ff @(posedge clk) begin
      if (en) begin
        if (!diff[DW]) begin
          rem_q[i] <= diff[DW-1:0];
          acc_q[i] <= {a_p[QW-2:0], 1'b1};
        end else begin
          rem_q[i] <= t[DW-1:0];
          acc_q[i] <= {a_p[QW-2:0], 1'b0};
        end
        den_q[i] <= d_p;
      end
    end
  end

  assign quo = acc_q[QW-1];

endmodule
`default_nettype wire

/* hw/rtl/cfo_isqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
module cfo_isqrt
  import cfo_pkg::*;
#(
  parameter int HW = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [2*HW:0] x,
  output logic [HW:0]   root
);

  localparam int XW = 2 * HW + 1;

  logic [XW-1:0] x_q [HW+1];
  logic [XW-1:0] r_q [HW+1];

  // one result bit per stage, highest power of four first
  for (genvar j = 0; j <= HW; j++) begin : g_step
    logic [XW-1:0] x_p;
    logic [XW-1:0] r_p;
    logic [XW-1:0] b_w;
    logic [XW:0]   rb;
    if (j == 0) begin : g_first
      assign x_p = x;
      assign r_p = '0;
    end else begin : g_next
      assign x_p = x_q[j-1];
      assign r_p = r_q[j-1];
    end
    assign b_w = XW'(1) << (2 * (HW - j));
    assign rb  = {1'b0, r_p} + {1'b0, b_w};
    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, x_p} >= rb) begin
          x_q[j] <= x_p - rb[XW-1:0];
          r_q[j] <= (r_p >> 1) + b_w;
        end else begin
          x_q[j] <= x_p;
          r_q[j] <= r_p >> 1;
        end
      end
    end
  end

  assign root = r_q[HW][HW:0];

endmodule
`default_nettype wire

/* hw/rtl/circular_field_obstacle_force.sv */
`timescale 1ns / 1ps
`default_nettype none
// Circular-field obstacle avoidance force, one obstacle observation per request.
// Input channel: in_valid / in_stall with the observation fields as ports.
// Output channel: out_valid / out_stall with force_x, force_y, active, saturated.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 weight,
// 1 influence distance, 2 field gain); other indexes are dropped. Write only
// while no request is in flight.
// Throughput: one request per cycle while in_stall is low. Path: from
// acceptance to out_valid a request passes two input stages, the
// bit-per-stage pipelined dividers (ratio divider 32+F stages, unit command
// divider 2F+1 stages followed by an F+1 stage square root, F = FRAC_BITS),
// three multiply stages and the output register.
// Reset: registers return to 1.0 (65536), all in-flight requests are dropped.
// Stall: the output register holds its request while out_stall is high; the
// pipeline keeps advancing as long as its last stage is empty, and in_stall
// rises only when the last stage holds a request behind the stalled output.
module circular_field_obstacle_force
  import cfo_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [31:0]   obs_vec_x,
  input  logic signed [31:0]   obs_vec_y,
  input  logic signed [31:0]   obs_vel_x,
  input  logic signed [31:0]   obs_vel_y,
  input  logic signed [31:0]   robot_vel_x,
  input  logic signed [31:0]   robot_vel_y,
  input  logic signed [31:0]   cmd_vel_x,
  input  logic signed [31:0]   cmd_vel_y,
  input  logic                 bypass_dir,
  input  logic [30:0]          target_dist,
  input  logic                 data_valid,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   force_x,
  output logic signed [31:0]   force_y,
  output logic                 active,
  output logic                 saturated,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int F     = FRAC_BITS;
  localparam int QR    = 32 + F;          // ratio quotient bits
  localparam int QU    = 2 * F + 1;       // squared unit component bits
  localparam int LAT_U = QU + F + 1;
  localparam int LAT_D = (QR > LAT_U) ? QR : LAT_U;
  localparam int DR    = LAT_D - QR;
  localparam int DU    = LAT_D - LAT_U;
  localparam int GW    = 32 + F;          // gain times unit component
  localparam int PMW   = 32 + F;          // mixed partial product width
  localparam int PW    = 64 + 2 * F;      // full product width
  localparam int L     = LAT_D + 5;       // pipeline register stages

  // configuration registers
  logic [CFG_W-1:0] weight, influence, gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight    <= CFG_RESET;
      influence <= CFG_RESET;
      gain      <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WEIGHT:    weight    <= cfg_data;
        CFG_INFLUENCE: influence <= cfg_data;
        CFG_GAIN:      gain      <= cfg_data;
        default:       ;
      endcase
    end
  end

  // flow control: the pipeline moves unless its last stage is full behind a
  // stalled output register
  logic [L-1:0] vld;
  logic         adv;

  assign adv      = !vld[L-1] || !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[L-2:0], in_valid};
  end

  // stage 1: magnitudes and products
  logic [31:0] m_vx, m_vy;
  logic [30:0] lim;

  assign m_vx = mag32(obs_vec_x);
  assign m_vy = mag32(obs_vec_y);
  assign lim  = (influence < target_dist) ? influence : target_dist;

  logic [63:0] s1_vx2, s1_vy2, s1_rv1, s1_rv2, s1_vu1, s1_vu2, s1_cx2, s1_cy2;
  logic [61:0] s1_lim2;
  logic        s1_nr1, s1_nr2, s1_nu1, s1_nu2;
  logic        s1_low_w, s1_dv, s1_vzero, s1_plus, s1_cxneg, s1_cyneg;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_vx2   <= 64'(m_vx) * 64'(m_vx);
      s1_vy2   <= 64'(m_vy) * 64'(m_vy);
      s1_rv1   <= 64'(mag32(robot_vel_x)) * 64'(m_vx);
      s1_rv2   <= 64'(mag32(robot_vel_y)) * 64'(m_vy);
      s1_vu1   <= 64'(m_vx) * 64'(mag32(obs_vel_x));
      s1_vu2   <= 64'(m_vy) * 64'(mag32(obs_vel_y));
      s1_cx2   <= 64'(mag32(cmd_vel_x)) * 64'(mag32(cmd_vel_x));
      s1_cy2   <= 64'(mag32(cmd_vel_y)) * 64'(mag32(cmd_vel_y));
      s1_lim2  <= 62'(lim) * 62'(lim);
      s1_nr1   <= robot_vel_x[31] ^ obs_vec_x[31];
      s1_nr2   <= robot_vel_y[31] ^ obs_vec_y[31];
      s1_nu1   <= obs_vec_x[31] ^ obs_vel_x[31];
      s1_nu2   <= obs_vec_y[31] ^ obs_vel_y[31];
      s1_low_w <= (45'(weight) * 45'(WEIGHT_SCALE)) < (45'(1) << F);
      s1_dv    <= data_valid;
      s1_vzero <= (obs_vec_x == 32'sd0) && (obs_vec_y == 32'sd0);
      s1_plus  <= bypass_dir;
      s1_cxneg <= cmd_vel_x[31];
      s1_cyneg <= cmd_vel_y[31];
    end
  end

  // stage 2: sums and dot products
  dot_t r_dot, u_dot;

  assign r_dot = dot_comb(s1_rv1, s1_rv2, s1_nr1, s1_nr2);
  assign u_dot = dot_comb(s1_vu1, s1_vu2, s1_nu1, s1_nu2);

  logic [63:0] s2_s2, s2_c2, s2_dm, s2_cx2, s2_cy2;
  logic [61:0] s2_lim2;
  logic        s2_dneg, s2_rneg, s2_low_w, s2_dv, s2_vzero, s2_plus, s2_cxneg, s2_cyneg;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_s2    <= s1_vx2 + s1_vy2;
      s2_c2    <= s1_cx2 + s1_cy2;
      s2_dm    <= u_dot.m;
      s2_dneg  <= u_dot.neg;
      s2_rneg  <= r_dot.neg;
      s2_cx2   <= s1_cx2;
      s2_cy2   <= s1_cy2;
      s2_lim2  <= s1_lim2;
      s2_low_w <= s1_low_w;
      s2_dv    <= s1_dv;
      s2_vzero <= s1_vzero;
      s2_plus  <= s1_plus;
      s2_cxneg <= s1_cxneg;
      s2_cyneg <= s1_cyneg;
    end
  end

  // drop conditions: small weight, missing data, zero vector, too far, moving away
  side_t side_s2, side_a;
  logic [$bits(side_t)-1:0] side_a_bits;

  assign side_s2.kill    = s2_low_w || !s2_dv || s2_vzero ||
                           (s2_s2 > {2'b00, s2_lim2}) || s2_rneg;
  assign side_s2.c2_zero = (s2_c2 == 64'd0);
  assign side_s2.neg_x   = s2_plus ^ s2_dneg ^ s2_cyneg;
  assign side_s2.neg_y   = !s2_plus ^ s2_dneg ^ s2_cxneg;

  cfo_delay #(.W($bits(side_t)), .N(LAT_D)) u_side_dly (
    .clk(clk), .en(adv), .din(side_s2), .dout(side_a_bits)
  );
  assign side_a = side_t'(side_a_bits);

  // ratio |v.u| / |v|^2 and unit command components
  logic [QR-1:0] ratio_q, ratio_a;
  logic [QU-1:0] ux2_q, uy2_q;
  logic [F:0]    nx_q, ny_q, nx_a, ny_a;

  cfo_div #(.NW(64 + F), .DW(64), .QW(QR)) u_div_ratio (
    .clk(clk), .en(adv), .num({s2_dm, {F{1'b0}}}), .den(s2_s2), .quo(ratio_q)
  );
  cfo_div #(.NW(64 + 2 * F), .DW(64), .QW(QU)) u_div_cx (
    .clk(clk), .en(adv), .num({s2_cx2, {(2 * F){1'b0}}}), .den(s2_c2), .quo(ux2_q)
  );
  cfo_div #(.NW(64 + 2 * F), .DW(64), .QW(QU)) u_div_cy (
    .clk(clk), .en(adv), .num({s2_cy2, {(2 * F){1'b0}}}), .den(s2_c2), .quo(uy2_q)
  );
  cfo_isqrt #(.HW(F)) u_sqrt_x (.clk(clk), .en(adv), .x(ux2_q), .root(nx_q));
  cfo_isqrt #(.HW(F)) u_sqrt_y (.clk(clk), .en(adv), .x(uy2_q), .root(ny_q));

  // align the two paths
  cfo_delay #(.W(QR), .N(DR)) u_ratio_dly (
    .clk(clk), .en(adv), .din(ratio_q), .dout(ratio_a)
  );
  cfo_delay #(.W(F + 1), .N(DU)) u_nx_dly (.clk(clk), .en(adv), .din(nx_q), .dout(nx_a));
  cfo_delay #(.W(F + 1), .N(DU)) u_ny_dly (.clk(clk), .en(adv), .din(ny_q), .dout(ny_a));

  // multiply stage 1: gain times unit component (zero command gives zero)
  logic [GW-1:0] m1_gx, m1_gy;
  logic [QR-1:0] m1_ratio;
  side_t         m1_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_gx    <= GW'(gain) * GW'(side_a.c2_zero ? '0 : ny_a);
      m1_gy    <= GW'(gain) * GW'(side_a.c2_zero ? '0 : nx_a);
      m1_ratio <= ratio_a;
      m1_side  <= side_a;
    end
  end

  // multiply stage 2: partial products split at bit 32
  logic [63:0]    m2_xll, m2_yll;
  logic [PMW-1:0] m2_xlh, m2_xhl, m2_ylh, m2_yhl;
  logic [2*F-1:0] m2_xhh, m2_yhh;
  side_t          m2_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_xll  <= 64'(m1_gx[31:0]) * 64'(m1_ratio[31:0]);
      m2_xlh  <= PMW'(m1_gx[31:0]) * PMW'(m1_ratio[QR-1:32]);
      m2_xhl  <= PMW'(m1_gx[GW-1:32]) * PMW'(m1_ratio[31:0]);
      m2_xhh  <= (2 * F)'(m1_gx[GW-1:32]) * (2 * F)'(m1_ratio[QR-1:32]);
      m2_yll  <= 64'(m1_gy[31:0]) * 64'(m1_ratio[31:0]);
      m2_ylh  <= PMW'(m1_gy[31:0]) * PMW'(m1_ratio[QR-1:32]);
      m2_yhl  <= PMW'(m1_gy[GW-1:32]) * PMW'(m1_ratio[31:0]);
      m2_yhh  <= (2 * F)'(m1_gy[GW-1:32]) * (2 * F)'(m1_ratio[QR-1:32]);
      m2_side <= m1_side;
    end
  end

  // multiply stage 3: sum the partials
  logic [PW-1:0] m3_px, m3_py;
  side_t         m3_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      m3_px   <= PW'(m2_xll) + ((PW'(m2_xlh) + PW'(m2_xhl)) << 32) + (PW'(m2_xhh) << 64);
      m3_py   <= PW'(m2_yll) + ((PW'(m2_ylh) + PW'(m2_yhl)) << 32) + (PW'(m2_yhh) << 64);
      m3_side <= m2_side;
    end
  end

  // scale down, clip to the signed 32-bit range, apply the sign
  function automatic logic [32:0] clip(input logic [63:0] m, input logic neg);
    logic [63:0] lim_c;
    logic [31:0] v;
    logic        sat;
    lim_c = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    sat   = m > lim_c;
    v     = sat ? lim_c[31:0] : m[31:0];
    return {sat, neg ? (32'd0 - v) : v};
  endfunction

  logic [32:0] cx, cy;

  assign cx = clip(m3_px[PW-1:2*F], m3_side.neg_x);
  assign cy = clip(m3_py[PW-1:2*F], m3_side.neg_y);

  // output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (!out_valid || !out_stall) out_valid <= vld[L-1];
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      force_x   <= m3_side.kill ? 32'sd0 : signed'(cx[31:0]);
      force_y   <= m3_side.kill ? 32'sd0 : signed'(cy[31:0]);
      active    <= !m3_side.kill;
      saturated <= !m3_side.kill && (cx[32] || cy[32]);
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/cfo_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module cfo_checker
  import cfo_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] force_x,
  input logic [31:0] force_y,
  input logic        active,
  input logic        saturated
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped under stall");

  // input backpressure only behind a stalled, full output
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // inactive result is all zero
  a_inactive_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !active |-> force_x == 32'd0 && force_y == 32'd0 && !saturated)
    else $error("inactive result not zero");

  // a clipped component sits at one end of the range
  a_sat_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> active &&
      (force_x == 32'h7FFF_FFFF || force_x == 32'h8000_0000 ||
       force_y == 32'h7FFF_FFFF || force_y == 32'h8000_0000))
    else $error("saturated flag without clipped component");

endmodule

bind circular_field_obstacle_force cfo_checker u_cfo_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .force_x(force_x),
  .force_y(force_y), .active(active), .saturated(saturated)
);
`default_nettype wire

/* verif/circular_field_obstacle_force_tb.sv */
`timescale 1ns / 1ps
module circular_field_obstacle_force_tb;
  import cfo_pkg::*;

  localparam int F = 16;
  // pipeline depth from acceptance to out_valid
  localparam int LAT = 56;
  localparam int WATCHDOG = 20000;

  typedef struct {
    logic [31:0] vx, vy, ux, uy, rx, ry, cx, cy;
    logic        byp;
    logic [30:0] mean;
    logic        dv;
  } obs_req_t;

  typedef struct packed {
    logic [31:0] fx, fy;
    logic        act, sat;
  } force_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] obs_vec_x = '0, obs_vec_y = '0, obs_vel_x = '0, obs_vel_y = '0;
  logic signed [31:0] robot_vel_x = '0, robot_vel_y = '0, cmd_vel_x = '0, cmd_vel_y = '0;
  logic bypass_dir = 1'b0;
  logic [30:0] target_dist = '0;
  logic data_valid = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] force_x, force_y;
  logic active, saturated;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  circular_field_obstacle_force dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copies of the configuration registers
  logic [30:0] weight_q = CFG_RESET, infl_q = CFG_RESET, gain_q = CFG_RESET;

  force_res_t pending_forces[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Work out the avoidance force of one request, all in exact wide integers.
  function automatic logic [31:0] clip_comp(logic [127:0] prod, logic neg, ref logic sat);
    logic [127:0] m;
    logic [127:0] lim;
    m   = prod >> (2 * F);
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (m > lim) begin
      m   = lim;
      sat = 1'b1;
    end
    return neg ? (32'd0 - m[31:0]) : m[31:0];
  endfunction

  function automatic logic [63:0] unit_mag(logic [63:0] cm, logic [63:0] c2);
    logic [127:0] q;
    logic [63:0]  r;
    if (c2 == 0) return 64'd0;
    q = ({64'd0, cm * cm} << (2 * F)) / c2;
    r = 0;
    // integer square root by bit search
    for (int b = 31; b >= 0; b--) begin
      if ({64'd0, (r | (64'd1 << b))} * (r | (64'd1 << b)) <= q) r = r | (64'd1 << b);
    end
    return r;
  endfunction

  function automatic force_res_t predict_force(obs_req_t q);
    force_res_t res;
    longint vx, vy, ux, uy, rx, ry, cx, cy;
    logic [63:0] s2, lim, c2, nx, ny, ratio;
    logic signed [65:0] rv, du;
    logic [65:0] dmag;
    logic negx, negy, dneg, sat;
    vx = $signed(q.vx); vy = $signed(q.vy); ux = $signed(q.ux); uy = $signed(q.uy);
    rx = $signed(q.rx); ry = $signed(q.ry); cx = $signed(q.cx); cy = $signed(q.cy);
    res = '{32'd0, 32'd0, 1'b0, 1'b0};
    if ({33'd0, weight_q} * 64'd10000 < (64'd1 << F)) return res;
    s2 = 64'(vx * vx) + 64'(vy * vy);
    if (!q.dv || s2 == 0) return res;
    lim = (infl_q < q.mean) ? infl_q : q.mean;
    if (s2 > lim * lim) return res;
    rv = 66'(rx * vx) + 66'(ry * vy);
    if (rv < 0) return res;
    du   = 66'(vx * ux) + 66'(vy * uy);
    dneg = du < 0;
    dmag = dneg ? -du : du;
    ratio = ({62'd0, dmag} << F) / s2;
    c2 = 64'(cx * cx) + 64'(cy * cy);
    nx = unit_mag(cx < 0 ? -cx : cx, c2);
    ny = unit_mag(cy < 0 ? -cy : cy, c2);
    negx = !q.byp ^ dneg ^ (cy < 0) ^ 1'b1;
    negy = !q.byp ^ dneg ^ (cx < 0);
    sat = 1'b0;
    res.fx  = clip_comp({64'd0, gain_q * ny} * ratio, negx, sat);
    res.fy  = clip_comp({64'd0, gain_q * nx} * ratio, negy, sat);
    res.act = 1'b1;
    res.sat = sat;
    return res;
  endfunction

  // Compare each accepted result against the oldest expectation.
  always @(posedge clk) begin
    force_res_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_forces.size() == 0) begin
          $error("unexpected result fx=%h fy=%h", force_x, force_y);
          errors++;
        end else begin
          e = pending_forces.pop_front();
          if (force_x !== e.fx) begin
            $error("force_x expected %h actual %h", e.fx, force_x); errors++;
          end
          if (force_y !== e.fy) begin
            $error("force_y expected %h actual %h", e.fy, force_y); errors++;
          end
          if (active !== e.act) begin
            $error("active expected %b actual %b", e.act, active); errors++;
          end
          if (saturated !== e.sat) begin
            $error("saturated expected %b actual %b", e.sat, saturated); errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: count cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Write one register, then drop the write enable.
  task automatic write_cfg(cfg_idx_t idx, logic [30:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_WEIGHT:    weight_q = val;
      CFG_INFLUENCE: infl_q   = val;
      default:       gain_q   = val;
    endcase
    @(posedge clk);
  endtask

  // Drop valid and wait for the pipeline to empty before touching the registers.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_forces.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  // Present one request after an optional idle gap and hold it until
  // accepted; the predictor runs at the accepting edge.
  task automatic send_obs(obs_req_t q, bit check_direct, force_res_t want);
    force_res_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    obs_vec_x   <= q.vx; obs_vec_y <= q.vy;
    obs_vel_x   <= q.ux; obs_vel_y <= q.uy;
    robot_vel_x <= q.rx; robot_vel_y <= q.ry;
    cmd_vel_x   <= q.cx; cmd_vel_y <= q.cy;
    bypass_dir  <= q.byp;
    target_dist <= q.mean;
    data_valid  <= q.dv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = predict_force(q);
    if (check_direct && p != want) begin
      $error("directed row disagrees with predictor fx=%h fy=%h", p.fx, p.fy);
      errors++;
    end
    pending_forces.push_back(check_direct ? want : p);
  endtask

  function automatic logic [31:0] rand_field(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(32'h0002_0000) - 32'h0001_0000;
      2: return $urandom_range(32'h0000_0400) - 32'h0000_0200;
      default: return $urandom_range(32'h0010_0000) - 32'h0008_0000;
    endcase
  endfunction

  function automatic obs_req_t random_obs();
    obs_req_t q;
    int m;
    m = $urandom_range(3);
    q.vx = rand_field(m == 0 ? 0 : 2); q.vy = rand_field(m == 0 ? 0 : 2);
    q.ux = rand_field(m); q.uy = rand_field(m);
    q.cx = rand_field($urandom_range(3)); q.cy = rand_field($urandom_range(3));
    // mostly steer the robot toward the obstacle so the force path is reached
    if ($urandom_range(9) < 8) begin
      q.rx = q.vx; q.ry = q.vy;
    end else begin
      q.rx = $urandom(); q.ry = $urandom();
    end
    q.byp  = $urandom_range(1);
    q.mean = ($urandom_range(9) == 0) ? 31'($urandom()) : 31'($urandom_range(32'h0004_0000));
    q.dv   = ($urandom_range(15) != 0);
    return q;
  endfunction

  localparam int N_DIR = 10;
  obs_req_t   dir_req[N_DIR];
  bit         dir_has_want[N_DIR];
  force_res_t dir_want[N_DIR];

  initial begin
    force_res_t zero_res;
    zero_res = '{32'd0, 32'd0, 1'b0, 1'b0};
    // Directed table: some rows carry a typed-in result, the rest use the predictor.
    // data not available
    dir_req[0] = '{32'h100, 32'h0, 32'h100, 0, 32'h100, 0, 32'h10000, 0, 1, 31'h10000, 0};
    dir_has_want[0] = 1; dir_want[0] = zero_res;
    // zero vector
    dir_req[1] = '{0, 0, 32'h100, 0, 0, 0, 32'h10000, 0, 1, 31'h10000, 1};
    dir_has_want[1] = 1; dir_want[1] = zero_res;
    // too far: vector at the extreme
    dir_req[2] = '{32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 1, 1, 0,
                   31'h7FFF_FFFF, 1};
    dir_has_want[2] = 1; dir_want[2] = zero_res;
    // moving away
    dir_req[3] = '{32'h100, 0, 32'h100, 0, 32'hFFFF_FF00, 0, 32'h10000, 0, 1, 31'h10000, 1};
    dir_has_want[3] = 1; dir_want[3] = zero_res;
    // zero command: active, no force
    dir_req[4] = '{32'h100, 0, 32'h100, 0, 32'h100, 0, 0, 0, 1, 31'h10000, 1};
    dir_has_want[4] = 1; dir_want[4] = '{32'd0, 32'd0, 1'b1, 1'b0};
    // ordinary active rows, both bypass sides
    dir_req[5] = '{32'h100, 32'h80, 32'h7FFF_FFFF, 32'h8000_0000, 32'h100, 32'h80,
                   32'h10000, 32'hFFFF_0000, 1, 31'h10000, 1};
    dir_has_want[5] = 0;
    dir_req[6] = '{32'hFFFF_FF00, 32'h40, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FF00, 0,
                   32'h8000_0000, 32'h7FFF_FFFF, 0, 31'h7FFF_FFFF, 1};
    dir_has_want[6] = 0;
    // out of range: tiny vector, huge obstacle velocity
    dir_req[7] = '{32'h1, 0, 32'h7FFF_FFFF, 0, 32'h1, 0, 0, 32'h10000, 1, 31'h10000, 1};
    dir_has_want[7] = 0;
    dir_req[8] = '{32'h1, 0, 32'h8000_0000, 0, 32'h1, 0, 0, 32'hFFFF_0000, 0, 31'h10000, 1};
    dir_has_want[8] = 0;
    // mean distance zero
    dir_req[9] = '{32'h1, 0, 32'h100, 0, 32'h1, 0, 32'h10000, 0, 1, 31'h0, 1};
    dir_has_want[9] = 1; dir_want[9] = zero_res;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) send_obs(dir_req[i], dir_has_want[i], dir_want[i]);
    drain();

    // Phases: configuration set, then idling mix; extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_cfg(CFG_WEIGHT, 31'd7); write_cfg(CFG_INFLUENCE, 31'h7FFF_FFFF);
             write_cfg(CFG_GAIN, 31'h7FFF_FFFF); end
        1: begin write_cfg(CFG_WEIGHT, 31'd6); write_cfg(CFG_GAIN, 31'd0); end
        2: begin write_cfg(CFG_WEIGHT, 31'h7FFF_FFFF); write_cfg(CFG_INFLUENCE, 31'd0);
             write_cfg(CFG_GAIN, 31'h10000); end
        3: begin write_cfg(CFG_INFLUENCE, 31'h40000); write_cfg(CFG_GAIN, 31'h0100_0000); end
        4: begin write_cfg(CFG_WEIGHT, 31'h10000); write_cfg(CFG_GAIN, 31'h8000); end
        default: begin write_cfg(CFG_INFLUENCE, 31'h7FFF_FFFF);
                   write_cfg(CFG_GAIN, 31'($urandom())); end
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      for (int n = 0; n < 315; n++) begin
        send_obs(random_obs(), 0, zero_res);
        // hold the sender once until the pipeline has emptied
        if (ph == 0 && n == 150) begin
          in_valid <= 1'b0;
          while (pending_forces.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    recv_stall_pct = 0;
    drain();
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
